// ===== design/assert_macros.svh =====
// assertion macros used by the checker file ath_check
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ATH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ath check failed");

// next-cycle implication
`define ATH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ath check failed");

`endif

// ===== design/ath_pkg.sv =====
// shared types and constants of the autoscaling time histogram
// used by ath_div and autoscaling_time_histogram
`default_nettype none

package ath_pkg;

    localparam int DEF_BINS        = 256;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam logic CFG_INITIAL_RANGE   = 1'b0;
    localparam logic CFG_SAMPLES_TO_SKIP = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic        start;
        logic [5:0]  steps;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/ath_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on ath_pkg for the request and response structs
`default_nettype none

module ath_div
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ath_pkg::div_req_t req,
    output ath_pkg::div_rsp_t      rsp
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] rem2;
    logic        ge;

    assign rem2 = {rem_reg, dvd_reg[63]};
    assign ge   = rem2 >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            // caller guarantees the top part of the dividend is below the divisor
            rem_next = 32'(req.dividend >> req.steps);
            dvd_next = req.dividend << (7'd64 - {1'b0, req.steps});
            dvs_next = req.divisor;
            q_next   = '0;
            cnt_next = req.steps;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? 32'(rem2 - {1'b0, dvs_reg}) : rem2[31:0];
            dvd_next = {dvd_reg[62:0], 1'b0};
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

`default_nettype wire

// ===== design/autoscaling_time_histogram.sv =====
// duration histogram with automatic range and bin folding
// depends on ath_pkg and ath_div
`default_nettype none

// Usage
//   A request is taken when start is high and busy is low. kind selects a bin
//   read (read_bin) or a duration sample (sample_time, 1/16 us). Each request
//   yields exactly one result, shown for one cycle with done high; the
//   receiver cannot stall, so results are never held.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 initial_range, 1 samples_to_skip) at once; the user must write only
//   while the block is idle; the block itself does not enforce this. A read
//   passes the read state, a skipped sample finishes straight from idle and
//   an overflow sample passes the range check and rescale test. A sample in a
//   bin adds the bin index division (one quotient bit per cycle) and a
//   read-modify-write of the bin memory; a rescale adds the mean division
//   (none when the mean saturates) and the fold sweep, one bin per cycle
//   through the memory. After reset busy stays high while both bin memories
//   are cleared; configuration writes are taken during that pass.

module autoscaling_time_histogram
#(
    parameter int BINS        = ath_pkg::DEF_BINS,
    parameter int COUNT_WIDTH = ath_pkg::DEF_COUNT_WIDTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    input  wire logic        kind,
    input  wire logic [31:0] sample_time,
    input  wire logic [7:0]  read_bin,
    output logic      [31:0] bin_count,
    output logic      [7:0]  bin_hit,
    output logic             was_overflow,
    output logic             was_skipped,
    output logic             did_rescale,
    output logic      [31:0] current_range,
    output logic      [31:0] pending_overflows,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int IDX_W = $clog2(BINS);
    localparam int DW    = 32 + IDX_W + 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_RA    = 4'd5;
    localparam logic [3:0] S_RMW   = 4'd6;
    localparam logic [3:0] S_TEST  = 4'd7;
    localparam logic [3:0] S_MEAN  = 4'd8;
    localparam logic [3:0] S_FOLD  = 4'd9;
    localparam logic [3:0] S_FLUSH = 4'd10;

    function automatic logic [31:0] dbl_sat_min1(input logic [31:0] v);
        logic [32:0] d;
        begin
            d = {v, 1'b0};
            if (d[32])
                dbl_sat_min1 = 32'hFFFF_FFFF;
            else if (d == 33'd0)
                dbl_sat_min1 = 32'd1;
            else
                dbl_sat_min1 = d[31:0];
        end
    endfunction

    function automatic logic [31:0] show_cnt(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+31:0] cx;
        begin
            cx = (COUNT_WIDTH + 32)'(c);
            show_cnt = (cx > (COUNT_WIDTH + 32)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cx[31:0];
        end
    endfunction

    // bin memories, one active and one kept all zero as the fold target
    logic [COUNT_WIDTH-1:0] mem_a [BINS];
    logic [COUNT_WIDTH-1:0] mem_b [BINS];
    logic [COUNT_WIDTH-1:0] rd_a_reg, rd_b_reg;

    logic [3:0]             state_reg, state_next;
    logic [IDX_W:0]         clr_reg, clr_next;
    logic [31:0]            sample_reg, sample_next;
    logic [7:0]             rbin_reg, rbin_next;
    logic [31:0]            init_reg, init_next;
    logic [3:0]             skip_cfg_reg, skip_cfg_next;
    logic [31:0]            range_reg, range_next;
    logic                   range_set_reg, range_set_next;
    logic [31:0]            counted_reg, counted_next;
    logic [3:0]             skipped_reg, skipped_next;
    logic [31:0]            tally_reg, tally_next;
    logic [63:0]            sum_reg, sum_next;
    logic                   bank_reg, bank_next;
    logic                   ovf_reg, ovf_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]       hit_reg, hit_next;
    logic [31:0]            new_range_reg, new_range_next;
    logic [IDX_W:0]         h_reg, h_next;
    logic [IDX_W-1:0]       nh_reg, nh_next;
    logic [32:0]            rem_reg, rem_next;
    logic                   pv_reg, pv_next;
    logic [IDX_W-1:0]       pnh_reg, pnh_next;
    logic [COUNT_WIDTH-1:0] acc_reg, acc_next;
    logic [IDX_W-1:0]       acc_nh_reg, acc_nh_next;
    logic                   acc_v_reg, acc_v_next;

    logic                   done_reg, done_next;
    logic [31:0]            o_count_reg, o_count_next;
    logic [7:0]             o_hit_reg, o_hit_next;
    logic                   o_ovf_reg, o_ovf_next;
    logic                   o_skp_reg, o_skp_next;
    logic                   o_resc_reg, o_resc_next;
    logic [31:0]            o_range_reg, o_range_next;
    logic [31:0]            o_pend_reg, o_pend_next;

    logic                   act_we, oth_we;
    logic [IDX_W-1:0]       act_waddr, oth_waddr, act_raddr;
    logic [COUNT_WIDTH-1:0] act_wdata, oth_wdata, act_rd;

    logic                   a_we, b_we;
    logic [IDX_W-1:0]       a_waddr, b_waddr;
    logic [COUNT_WIDTH-1:0] a_wdata, b_wdata;

    ath_pkg::div_req_t      div_req;
    ath_pkg::div_rsp_t      div_rsp;

    logic [DW-1:0]          idx_dvd;
    logic [DW-1:0]          idx_lim;
    logic [64:0]            sum_add;
    logic [34:0]            tally_x5;
    logic                   fold_issue;
    logic [32:0]            rem_step;
    logic [COUNT_WIDTH:0]   acc_add;

    ath_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign act_rd = bank_reg ? rd_b_reg : rd_a_reg;

    // round(sample*BINS/range) as floor((sample*BINS + range/2) / range)
    assign idx_dvd  = DW'(64'(sample_reg) * 64'(BINS)) + DW'(range_reg >> 1);
    assign idx_lim  = DW'(64'(range_reg) * 64'(BINS));
    assign sum_add  = {1'b0, sum_reg} + 65'(sample_reg);
    assign tally_x5 = {1'b0, tally_reg, 2'b00} + 35'(tally_reg);

    assign fold_issue = h_reg < (IDX_W + 1)'(BINS);
    // new range never drops below the old one, so one subtract keeps up
    assign rem_step   = rem_reg + {1'b0, range_reg};
    assign acc_add    = {1'b0, acc_reg} + {1'b0, act_rd};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sample_next    = sample_reg;
        rbin_next      = rbin_reg;
        init_next      = init_reg;
        skip_cfg_next  = skip_cfg_reg;
        range_next     = range_reg;
        range_set_next = range_set_reg;
        counted_next   = counted_reg;
        skipped_next   = skipped_reg;
        tally_next     = tally_reg;
        sum_next       = sum_reg;
        bank_next      = bank_reg;
        ovf_next       = ovf_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        new_range_next = new_range_reg;
        h_next         = h_reg;
        nh_next        = nh_reg;
        rem_next       = rem_reg;
        pv_next        = 1'b0;
        pnh_next       = pnh_reg;
        acc_next       = acc_reg;
        acc_nh_next    = acc_nh_reg;
        acc_v_next     = acc_v_reg;
        done_next      = 1'b0;
        o_count_next   = o_count_reg;
        o_hit_next     = o_hit_reg;
        o_ovf_next     = o_ovf_reg;
        o_skp_next     = o_skp_reg;
        o_resc_next    = o_resc_reg;
        o_range_next   = o_range_reg;
        o_pend_next    = o_pend_reg;
        act_we         = 1'b0;
        act_waddr      = '0;
        act_wdata      = '0;
        act_raddr      = '0;
        oth_we         = 1'b0;
        oth_waddr      = '0;
        oth_wdata      = '0;
        div_req        = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                ath_pkg::CFG_INITIAL_RANGE:   init_next     = cfg_data;
                ath_pkg::CFG_SAMPLES_TO_SKIP: skip_cfg_next = cfg_data[3:0];
            endcase
        end

        unique case (state_reg)
            S_CLR:
            begin
                act_we    = 1'b1;
                act_waddr = clr_reg[IDX_W-1:0];
                oth_we    = 1'b1;
                oth_waddr = clr_reg[IDX_W-1:0];
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (IDX_W + 1)'(BINS - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    sample_next = sample_time;
                    rbin_next   = read_bin;
                    if (kind == ath_pkg::KIND_READ)
                    begin
                        act_raddr  = IDX_W'(read_bin);
                        state_next = S_RD;
                    end
                    else if (skipped_reg < skip_cfg_reg)
                    begin
                        skipped_next = skipped_reg + 4'd1;
                        done_next    = 1'b1;
                        o_count_next = '0;
                        o_hit_next   = '0;
                        o_ovf_next   = 1'b0;
                        o_skp_next   = 1'b1;
                        o_resc_next  = 1'b0;
                        o_range_next = range_reg;
                        o_pend_next  = tally_reg;
                    end
                    else
                    begin
                        if (counted_reg != 32'hFFFF_FFFF)
                            counted_next = counted_reg + 32'd1;
                        if (!range_set_reg)
                        begin
                            range_next     = (init_reg != 32'd0) ? init_reg
                                                                 : dbl_sat_min1(sample_time);
                            range_set_next = 1'b1;
                        end
                        state_next = S_CHK;
                    end
                end
            end

            S_RD:
            begin
                done_next    = 1'b1;
                o_count_next = (32'(rbin_reg) < 32'(BINS)) ? show_cnt(act_rd) : 32'd0;
                o_hit_next   = rbin_reg;
                o_ovf_next   = 1'b0;
                o_skp_next   = 1'b0;
                o_resc_next  = 1'b0;
                o_range_next = range_reg;
                o_pend_next  = tally_reg;
                state_next   = S_IDLE;
            end

            S_CHK:
            begin
                if (idx_dvd >= idx_lim)
                begin
                    ovf_next = 1'b1;
                    cnt_next = '0;
                    hit_next = '0;
                    if (tally_reg != 32'hFFFF_FFFF)
                        tally_next = tally_reg + 32'd1;
                    sum_next   = sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
                    state_next = S_TEST;
                end
                else
                begin
                    ovf_next         = 1'b0;
                    div_req.start    = 1'b1;
                    div_req.steps    = 6'(IDX_W);
                    div_req.dividend = 64'(idx_dvd);
                    div_req.divisor  = range_reg;
                    state_next       = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    hit_next   = div_rsp.quotient[IDX_W-1:0];
                    state_next = S_RA;
                end
            end

            S_RA:
            begin
                act_raddr  = hit_reg;
                state_next = S_RMW;
            end

            S_RMW:
            begin
                act_we     = 1'b1;
                act_waddr  = hit_reg;
                act_wdata  = (act_rd == CNT_MAX) ? CNT_MAX : act_rd + 1'b1;
                cnt_next   = act_wdata;
                state_next = S_TEST;
            end

            S_TEST:
            begin
                h_next     = '0;
                nh_next    = '0;
                rem_next   = '0;
                acc_v_next = 1'b0;
                if (tally_reg > 32'd1 && tally_x5 > 35'(counted_reg))
                begin
                    if (sum_reg >= {1'b0, tally_reg, 31'd0})
                    begin
                        new_range_next = 32'hFFFF_FFFF;
                        state_next     = S_FOLD;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.steps    = 6'd31;
                        div_req.dividend = sum_reg;
                        div_req.divisor  = tally_reg;
                        state_next       = S_MEAN;
                    end
                end
                else
                begin
                    done_next    = 1'b1;
                    o_count_next = show_cnt(cnt_reg);
                    o_hit_next   = 8'(hit_reg);
                    o_ovf_next   = ovf_reg;
                    o_skp_next   = 1'b0;
                    o_resc_next  = 1'b0;
                    o_range_next = range_reg;
                    o_pend_next  = tally_reg;
                    state_next   = S_IDLE;
                end
            end

            S_MEAN:
            begin
                if (div_rsp.done)
                begin
                    new_range_next = (div_rsp.quotient == 32'd0) ? 32'd1
                                                                 : {div_rsp.quotient[30:0], 1'b0};
                    state_next     = S_FOLD;
                end
            end

            S_FOLD:
            begin
                // read and clear the old bin, step the target index
                if (fold_issue)
                begin
                    act_raddr = h_reg[IDX_W-1:0];
                    act_we    = 1'b1;
                    act_waddr = h_reg[IDX_W-1:0];
                    pv_next   = 1'b1;
                    pnh_next  = nh_reg;
                    h_next    = h_reg + 1'b1;
                    if (rem_step >= {1'b0, new_range_reg})
                    begin
                        nh_next  = nh_reg + 1'b1;
                        rem_next = rem_step - {1'b0, new_range_reg};
                    end
                    else
                        rem_next = rem_step;
                end
                // merge runs of equal target bins, write out on change
                if (pv_reg)
                begin
                    if (acc_v_reg && pnh_reg == acc_nh_reg)
                        acc_next = acc_add[COUNT_WIDTH] ? CNT_MAX : acc_add[COUNT_WIDTH-1:0];
                    else
                    begin
                        oth_we      = acc_v_reg;
                        oth_waddr   = acc_nh_reg;
                        oth_wdata   = acc_reg;
                        acc_next    = act_rd;
                        acc_nh_next = pnh_reg;
                        acc_v_next  = 1'b1;
                    end
                end
                if (!fold_issue && !pv_reg)
                    state_next = S_FLUSH;
            end

            S_FLUSH:
            begin
                oth_we       = acc_v_reg;
                oth_waddr    = acc_nh_reg;
                oth_wdata    = acc_reg;
                bank_next    = ~bank_reg;
                range_next   = new_range_reg;
                tally_next   = '0;
                sum_next     = '0;
                done_next    = 1'b1;
                o_count_next = show_cnt(cnt_reg);
                o_hit_next   = 8'(hit_reg);
                o_ovf_next   = ovf_reg;
                o_skp_next   = 1'b0;
                o_resc_next  = 1'b1;
                o_range_next = new_range_reg;
                o_pend_next  = '0;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (bank_reg)
        begin
            b_we = act_we;  b_waddr = act_waddr;  b_wdata = act_wdata;
            a_we = oth_we;  a_waddr = oth_waddr;  a_wdata = oth_wdata;
        end
        else
        begin
            a_we = act_we;  a_waddr = act_waddr;  a_wdata = act_wdata;
            b_we = oth_we;  b_waddr = oth_waddr;  b_wdata = oth_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
            mem_a[a_waddr] <= a_wdata;
        rd_a_reg <= mem_a[act_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            mem_b[b_waddr] <= b_wdata;
        rd_b_reg <= mem_b[act_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            init_reg      <= 32'd0;
            skip_cfg_reg  <= 4'd1;
            range_reg     <= '0;
            range_set_reg <= 1'b0;
            counted_reg   <= '0;
            skipped_reg   <= '0;
            tally_reg     <= '0;
            sum_reg       <= '0;
            bank_reg      <= 1'b0;
            h_reg         <= '0;
            pv_reg        <= 1'b0;
            acc_v_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            init_reg      <= init_next;
            skip_cfg_reg  <= skip_cfg_next;
            range_reg     <= range_next;
            range_set_reg <= range_set_next;
            counted_reg   <= counted_next;
            skipped_reg   <= skipped_next;
            tally_reg     <= tally_next;
            sum_reg       <= sum_next;
            bank_reg      <= bank_next;
            h_reg         <= h_next;
            pv_reg        <= pv_next;
            acc_v_reg     <= acc_v_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        rbin_reg      <= rbin_next;
        ovf_reg       <= ovf_next;
        cnt_reg       <= cnt_next;
        hit_reg       <= hit_next;
        new_range_reg <= new_range_next;
        nh_reg        <= nh_next;
        rem_reg       <= rem_next;
        pnh_reg       <= pnh_next;
        acc_reg       <= acc_next;
        acc_nh_reg    <= acc_nh_next;
        o_count_reg   <= o_count_next;
        o_hit_reg     <= o_hit_next;
        o_ovf_reg     <= o_ovf_next;
        o_skp_reg     <= o_skp_next;
        o_resc_reg    <= o_resc_next;
        o_range_reg   <= o_range_next;
        o_pend_reg    <= o_pend_next;
    end

    assign busy              = state_reg != S_IDLE;
    assign done              = done_reg;
    assign bin_count         = o_count_reg;
    assign bin_hit           = o_hit_reg;
    assign was_overflow      = o_ovf_reg;
    assign was_skipped       = o_skp_reg;
    assign did_rescale       = o_resc_reg;
    assign current_range     = o_range_reg;
    assign pending_overflows = o_pend_reg;

endmodule

`default_nettype wire

// ===== design/ath_check.sv =====
// port-level checks of autoscaling_time_histogram, bound to the top level
// depends on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ath_check
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] bin_count,
    input wire logic [7:0]  bin_hit,
    input wire logic        was_overflow,
    input wire logic        was_skipped,
    input wire logic        did_rescale,
    input wire logic [31:0] pending_overflows
);

    // an accepted request is either finished next cycle or still being worked on
    `ATH_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)

    // a skipped sample never overflows or rescales and reports nothing
    `ATH_ASSERT_IMP(a_skip_clean, done && was_skipped,
                    !was_overflow && !did_rescale && bin_count == 32'd0 && bin_hit == 8'd0)

    // an overflow sample does not hit a bin
    `ATH_ASSERT_IMP(a_ovf_no_bin, done && was_overflow, bin_count == 32'd0 && bin_hit == 8'd0)

    // a rescale clears the overflow statistics
    `ATH_ASSERT_IMP(a_rescale_clears, done && did_rescale, pending_overflows == 32'd0)

endmodule

bind autoscaling_time_histogram ath_check u_ath_check (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench of autoscaling_time_histogram
// depends on ath_pkg and the block under test; predicts every result itself
`default_nettype none

module tb_top;

    localparam int NBINS = 256;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef struct {
        bit          is_cfg;
        logic        cidx;
        logic [31:0] cdata;
        logic        kind;
        logic [31:0] stime;
        logic [7:0]  rbin;
    } request_t;

    typedef struct {
        logic [31:0] count;
        logic [7:0]  hit;
        logic        ovf;
        logic        skp;
        logic        resc;
        logic [31:0] rng;
        logic [31:0] povf;
    } hist_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        kind;
    logic [31:0] sample_time;
    logic [7:0]  read_bin;
    logic [31:0] bin_count;
    logic [7:0]  bin_hit;
    logic        was_overflow;
    logic        was_skipped;
    logic        did_rescale;
    logic [31:0] current_range;
    logic [31:0] pending_overflows;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    autoscaling_time_histogram DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .kind(kind), .sample_time(sample_time), .read_bin(read_bin),
        .bin_count(bin_count), .bin_hit(bin_hit), .was_overflow(was_overflow),
        .was_skipped(was_skipped), .did_rescale(did_rescale),
        .current_range(current_range), .pending_overflows(pending_overflows),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // histogram shadow state
    logic [31:0] hist_bins [NBINS];
    logic [31:0] fold_bins [NBINS];
    logic [31:0] sh_init_range;
    logic [3:0]  sh_skip_cfg;
    logic [31:0] sh_range;
    bit          sh_range_set;
    logic [31:0] sh_counted;
    logic [3:0]  sh_skipped;
    logic [31:0] sh_ovf_tally;
    logic [63:0] sh_ovf_sum;

    request_t     request_q [$];
    hist_result_t expected_q [$];
    int           errors;
    int           gap_left;
    int           settle;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] double_clip(logic [63:0] v);
        logic [64:0] d;
        d = {v, 1'b0};
        if (d > 65'hFFFF_FFFF) d = 65'hFFFF_FFFF;
        if (d == 0) d = 1;
        return d[31:0];
    endfunction

    function automatic logic [31:0] add_clip(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = a + b;
        return s[32] ? CNT_MAX : s[31:0];
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
        return $urandom_range(10, 70);
    endfunction

    task automatic predict_histogram(request_t r);
        hist_result_t e;
        logic [63:0]  idx;
        logic [31:0]  old_r;
        logic [31:0]  new_r;
        logic [63:0]  nh;
        e = '{default: '0};
        if (r.kind == ath_pkg::KIND_READ) begin
            e.count = hist_bins[r.rbin];
            e.hit = r.rbin;
        end else if (sh_skipped < sh_skip_cfg) begin
            sh_skipped = sh_skipped + 1'b1;
            e.skp = 1'b1;
        end else begin
            if (sh_counted != 32'hFFFF_FFFF) sh_counted++;
            if (!sh_range_set) begin
                sh_range = (sh_init_range != 0) ? sh_init_range : double_clip({32'd0, r.stime});
                sh_range_set = 1;
            end
            if (sh_range == 0) sh_range = 1;
            idx = ({32'd0, r.stime} * NBINS + {33'd0, sh_range[31:1]}) / {32'd0, sh_range};
            if (idx >= NBINS) begin
                e.ovf = 1'b1;
                if (sh_ovf_tally != 32'hFFFF_FFFF) sh_ovf_tally++;
                if (sh_ovf_sum > ~64'd0 - r.stime) sh_ovf_sum = ~64'd0;
                else sh_ovf_sum = sh_ovf_sum + r.stime;
            end else begin
                hist_bins[idx] = add_clip(hist_bins[idx], 32'd1);
                e.count = hist_bins[idx];
                e.hit = idx[7:0];
            end
            if (sh_ovf_tally > 1 && sh_ovf_tally > sh_counted / 5) begin
                old_r = sh_range;
                new_r = double_clip(sh_ovf_sum / sh_ovf_tally);
                for (int h = 0; h < NBINS; h++) fold_bins[h] = '0;
                for (int h = 0; h < NBINS; h++) begin
                    nh = (64'(h) * old_r) / new_r;
                    if (nh >= NBINS) nh = NBINS - 1;
                    fold_bins[nh] = add_clip(fold_bins[nh], hist_bins[h]);
                end
                for (int h = 0; h < NBINS; h++) hist_bins[h] = fold_bins[h];
                sh_range = new_r;
                sh_ovf_tally = 0;
                sh_ovf_sum = 0;
                e.resc = 1'b1;
            end
        end
        e.rng = sh_range;
        e.povf = sh_ovf_tally;
        expected_q.push_back(e);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // driver: one request or register write at a time
    always @(posedge clk or negedge rst_n) begin
        bit       fire;
        bit       next_start;
        request_t hd;
        if (!rst_n) begin
            start <= 1'b0;
            cfg_we <= 1'b0;
        end else begin
            fire = start && !busy;
            next_start = start && !fire;
            if (fire) begin
                predict_histogram(request_q.pop_front());
            end
            cfg_we <= 1'b0;
            if (!next_start && request_q.size() > 0) begin
                hd = request_q[0];
                if (hd.is_cfg) begin
                    if (expected_q.size() == 0 && !busy) settle++;
                    else settle = 0;
                    if (settle > 6) begin
                        cfg_we <= 1'b1;
                        cfg_index <= hd.cidx;
                        cfg_data <= hd.cdata;
                        if (hd.cidx == ath_pkg::CFG_INITIAL_RANGE) sh_init_range = hd.cdata;
                        else sh_skip_cfg = hd.cdata[3:0];
                        void'(request_q.pop_front());
                        settle = 0;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    next_start = 1;
                    kind <= hd.kind;
                    sample_time <= hd.stime;
                    read_bin <= hd.rbin;
                    gap_left = pick_gap();
                end
            end
            start <= next_start;
        end
    end

    // monitor: results cannot be held off, check every strobe
    always @(posedge clk) begin
        hist_result_t e;
        if (rst_n && done) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result bin_hit", bin_hit, 64'd0);
            end else begin
                e = expected_q.pop_front();
                if (bin_count !== e.count) report_mismatch("bin_count", bin_count, e.count);
                if (bin_hit !== e.hit) report_mismatch("bin_hit", bin_hit, e.hit);
                if (was_overflow !== e.ovf) report_mismatch("was_overflow", was_overflow, e.ovf);
                if (was_skipped !== e.skp) report_mismatch("was_skipped", was_skipped, e.skp);
                if (did_rescale !== e.resc) report_mismatch("did_rescale", did_rescale, e.resc);
                if (current_range !== e.rng)
                    report_mismatch("current_range", current_range, e.rng);
                if (pending_overflows !== e.povf)
                    report_mismatch("pending_overflows", pending_overflows, e.povf);
            end
        end
    end

    task automatic add_sample(logic [31:0] s);
        request_q.push_back('{0, ath_pkg::CFG_INITIAL_RANGE, 32'd0, ath_pkg::KIND_SAMPLE,
                              s, 8'd0});
    endtask

    task automatic add_read(logic [7:0] b);
        request_q.push_back('{0, ath_pkg::CFG_INITIAL_RANGE, 32'd0, ath_pkg::KIND_READ,
                              $urandom(), b});
    endtask

    task automatic add_cfg(logic idx, logic [31:0] d);
        request_q.push_back('{1, idx, d, ath_pkg::KIND_SAMPLE, 32'd0, 8'd0});
    endtask

    initial begin
        int pick;
        errors = 0;
        gap_left = 0;
        settle = 0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ath_pkg::CFG_INITIAL_RANGE;
        cfg_data = '0;
        kind = ath_pkg::KIND_SAMPLE;
        sample_time = '0;
        read_bin = '0;
        for (int h = 0; h < NBINS; h++) hist_bins[h] = '0;
        sh_init_range = 0;
        sh_skip_cfg = 4'd1;
        sh_range = 0;
        sh_range_set = 0;
        sh_counted = 0;
        sh_skipped = 0;
        sh_ovf_tally = 0;
        sh_ovf_sum = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: skipping, range from first sample, rounding edges, overflow, reads
        add_cfg(ath_pkg::CFG_INITIAL_RANGE, 32'd0);
        add_cfg(ath_pkg::CFG_SAMPLES_TO_SKIP, 32'd3);
        add_read(8'd0);
        add_sample(32'hFFFF_FFFF);
        add_sample(32'd0);
        add_sample(32'd7);
        add_sample(32'd1000);
        add_sample(32'd0);
        add_sample(32'd3);
        add_sample(32'd4);
        add_sample(32'd1995);
        add_sample(32'd1996);
        add_read(8'd128);
        add_read(8'd255);
        add_sample(32'hFFFF_FFFF);
        add_sample(32'hFFFF_FFFF);
        add_sample(32'd1000);
        add_read(8'd0);
        add_read(8'd127);
        add_cfg(ath_pkg::CFG_SAMPLES_TO_SKIP, 32'd0);
        add_cfg(ath_pkg::CFG_INITIAL_RANGE, 32'hFFFF_FFFF);
        add_sample(32'h8000_0000);
        add_sample(32'h0000_0001);
        add_sample(32'hFFFF_FFFF);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: add_cfg(ath_pkg::CFG_SAMPLES_TO_SKIP, 32'd15);
                1: add_cfg(ath_pkg::CFG_SAMPLES_TO_SKIP, 32'd0);
                default: add_cfg(ath_pkg::CFG_SAMPLES_TO_SKIP, $urandom());
            endcase
            add_cfg(ath_pkg::CFG_INITIAL_RANGE, (ph == 2) ? 32'd0 : $urandom());
            for (int i = 0; i < 222; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) add_read($urandom());
                else if (pick < 62) add_sample($urandom_range(0, 4000));
                else if (pick < 80) add_sample($urandom_range(0, 1 << (ph * 4 + 8)));
                else if (pick < 92) add_sample($urandom_range(4000, 2000000));
                else add_sample($urandom());
            end
        end

        wait (request_q.size() == 0 && expected_q.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #30000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/ath_pkg.sv
design/ath_div.sv
design/autoscaling_time_histogram.sv
design/ath_check.sv
verif/tb_top.sv
